### sv/ptsc_pkg.sv
// types and constants shared by the priority task scheduler
// slot record layout, opcodes, status codes, table access request, result bundle and sequencer states
// no dependencies
package ptsc_pkg;

    localparam int SLOT_W = 4;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SLEEP  = 2'd1,
        OP_CREATE = 2'd2,
        OP_REINIT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_SCHED   = 3'd0,
        STAT_CREATED = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_REINIT  = 3'd4
    } status_t;

    typedef struct packed {
        slot_t       succ;
        logic [7:0]  prio;
        logic        sleeping;
        logic [31:0] sleep_left;
        logic [31:0] ctx;
        logic [31:0] cpu;
        logic [31:0] id;
    } slot_rec_t;

    typedef struct packed {
        logic      re;
        slot_t     raddr;
        logic      we;
        slot_t     waddr;
        slot_rec_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] ctx;
        slot_t       slot;
        logic [31:0] id;
        logic [31:0] cpu;
        slot_t       tasks;
        logic [31:0] new_id;
        status_t     status;
    } result_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_CUR,
        S_CUR_DAT,
        S_CR_WR,
        S_W1_RD,
        S_W1_DAT,
        S_W2_RD,
        S_W2_DAT,
        S_PICK_RD,
        S_PICK_DAT,
        S_DONE
    } state_t;

    function automatic slot_rec_t main_rec();
        slot_rec_t r;
        r      = '0;
        r.prio = 8'd1;
        return r;
    endfunction

endpackage

### sv/priority_task_scheduler.sv
// priority task scheduler top level: sequencer, task table and output register
// tick and sleep walk the ring counting sleepers down, then scan it for the highest priority;
// reinitialise, ignored sleep, full pool and create finish without a walk
// one item at a time: the input stays closed through the ring walks until the result is handed on
// reset: aresetn low clears current slot, task count and id counter (id restarts at one);
// after release, slot 0 is written as the main task before beats are taken
module priority_task_scheduler
    import ptsc_pkg::*;
#(
    parameter int POOL_SIZE = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: context_ptr[31:0], task_priority[39:32], sleep_length[71:40]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]   s_tuser,
    // m_tdata: resume_context[31:0], running_slot[35:32], running_id[67:36],
    // running_cpu_time[99:68], tasks_present[103:100], new_id[135:104]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]   m_tuser
);

    mem_req_t  req;
    slot_rec_t rdata;
    result_t   res;
    logic      res_valid;
    logic      res_ready;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [135:0] m_tdata_reg, m_tdata_next;
    logic [2:0]   m_tuser_reg, m_tuser_next;

    // sequencer owns all table traffic
    ptsc_ctrl #(
        .POOL_SIZE(POOL_SIZE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (opcode_t'(s_tuser)),
        .in_ctx   (s_tdata[31:0]),
        .in_prio  (s_tdata[39:32]),
        .in_len   (s_tdata[71:40]),
        .req      (req),
        .rdata    (rdata),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    ptsc_table #(
        .POOL_SIZE(POOL_SIZE)
    ) u_table (
        .aclk (aclk),
        .req  (req),
        .rdata(rdata)
    );

    // output register frees the sequencer while a result beat waits
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.new_id, res.tasks, res.cpu, res.id, res.slot, res.ctx};
            m_tuser_next  = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted beat keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after accept");

    // a reinitialise result always reports the main task
    a_reinit_main: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_REINIT |-> m_tdata[35:32] == 4'd0)
        else $error("reinitialise result not on main slot");

    // reported slot stays inside the table
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[35:32] <= 4'(POOL_SIZE))
        else $error("running slot outside table");

endmodule

### sv/ptsc_table.sv
// task table memory: one write port, one read port with registered data
// depends on ptsc_pkg
module ptsc_table
    import ptsc_pkg::*;
#(
    parameter int POOL_SIZE = 8
) (
    input  logic      aclk,
    input  mem_req_t  req,
    output slot_rec_t rdata
);

    localparam int NSLOTS = POOL_SIZE + 1;
    localparam int ADDR_W = $clog2(NSLOTS);

    slot_rec_t mem [NSLOTS];
    slot_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/ptsc_ctrl.sv
// scheduler sequencer: read-modify-write walks over the task table ring
// depends on ptsc_pkg, drives ptsc_table through a mem_req_t
module ptsc_ctrl
    import ptsc_pkg::*;
#(
    parameter int POOL_SIZE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  opcode_t     in_op,
    input  logic [31:0] in_ctx,
    input  logic [7:0]  in_prio,
    input  logic [31:0] in_len,
    output mem_req_t    req,
    input  slot_rec_t   rdata,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    state_t      state_reg, state_next;
    opcode_t     op_reg, op_next;
    logic [31:0] ctx_reg, ctx_next;
    logic [7:0]  prio_reg, prio_next;
    logic [31:0] len_reg, len_next;
    slot_t       cur_reg, cur_next;
    slot_t       count_reg, count_next;
    logic [31:0] nid_reg, nid_next;
    slot_t       t_reg, t_next;
    slot_t       start_reg, start_next;
    slot_t       best_reg, best_next;
    logic [7:0]  bprio_reg, bprio_next;
    logic        found_reg, found_next;
    slot_rec_t   hold_reg, hold_next;
    result_t     res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cur_reg   <= '0;
            count_reg <= '0;
            nid_reg   <= 32'd1;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            nid_reg   <= nid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        ctx_reg   <= ctx_next;
        prio_reg  <= prio_next;
        len_reg   <= len_next;
        t_reg     <= t_next;
        start_reg <= start_next;
        best_reg  <= best_next;
        bprio_reg <= bprio_next;
        found_reg <= found_next;
        hold_reg  <= hold_next;
        res_reg   <= res_next;
    end

    always_comb begin
        slot_rec_t r;
        slot_t     s;
        state_next = state_reg;
        op_next    = op_reg;
        ctx_next   = ctx_reg;
        prio_next  = prio_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        nid_next   = nid_reg;
        t_next     = t_reg;
        start_next = start_reg;
        best_next  = best_reg;
        bprio_next = bprio_reg;
        found_next = found_reg;
        hold_next  = hold_reg;
        res_next   = res_reg;
        req        = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        r          = rdata;
        s          = count_reg + slot_t'(1);

        case (state_reg)
            S_INIT: begin
                req.we     = 1'b1;
                req.waddr  = '0;
                req.wdata  = main_rec();
                state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next   = in_op;
                    ctx_next  = in_ctx;
                    prio_next = in_prio;
                    len_next  = in_len;
                    if (in_op == OP_REINIT) begin
                        req.we         = 1'b1;
                        req.waddr      = '0;
                        req.wdata      = main_rec();
                        cur_next       = '0;
                        count_next     = '0;
                        res_next       = '0;
                        res_next.status = STAT_REINIT;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_RD_CUR;
                    end
                end
            end
            S_RD_CUR: begin
                req.re     = 1'b1;
                req.raddr  = cur_reg;
                state_next = S_CUR_DAT;
            end
            S_CUR_DAT: begin
                res_next.ctx    = r.ctx;
                res_next.slot   = cur_reg;
                res_next.id     = r.id;
                res_next.cpu    = r.cpu;
                res_next.new_id = '0;
                if (op_reg == OP_CREATE) begin
                    if (count_reg >= slot_t'(POOL_SIZE)) begin
                        res_next.status = STAT_FULL;
                        state_next      = S_DONE;
                    end else begin
                        // new slot goes in right after the current one
                        req.we            = 1'b1;
                        req.waddr         = s;
                        req.wdata         = '0;
                        req.wdata.succ    = r.succ;
                        req.wdata.prio    = prio_reg;
                        req.wdata.ctx     = ctx_reg;
                        req.wdata.id      = nid_reg;
                        hold_next         = r;
                        hold_next.succ    = s;
                        count_next        = s;
                        nid_next          = nid_reg + 32'd1;
                        res_next.new_id   = nid_reg;
                        res_next.status   = STAT_CREATED;
                        state_next        = S_CR_WR;
                    end
                end else if (op_reg == OP_SLEEP && len_reg == 32'd0) begin
                    res_next.status = STAT_IGNORED;
                    state_next      = S_DONE;
                end else begin
                    req.we    = 1'b1;
                    req.waddr = cur_reg;
                    req.wdata = r;
                    req.wdata.ctx = ctx_reg;
                    if (op_reg == OP_SLEEP) begin
                        req.wdata.sleeping   = 1'b1;
                        req.wdata.sleep_left = len_reg;
                    end
                    start_next = r.succ;
                    t_next     = cur_reg;
                    state_next = S_W1_RD;
                end
            end
            S_CR_WR: begin
                req.we     = 1'b1;
                req.waddr  = cur_reg;
                req.wdata  = hold_reg;
                state_next = S_DONE;
            end
            S_W1_RD: begin
                req.re     = 1'b1;
                req.raddr  = t_reg;
                state_next = S_W1_DAT;
            end
            S_W1_DAT: begin
                // count down a sleeper and wake it at zero
                if (r.sleeping) begin
                    if (r.sleep_left != 32'd0) begin
                        r.sleep_left = r.sleep_left - 32'd1;
                    end
                    if (r.sleep_left == 32'd0) begin
                        r.sleeping = 1'b0;
                    end
                end
                req.we    = 1'b1;
                req.waddr = t_reg;
                req.wdata = r;
                t_next    = r.succ;
                if (r.succ == cur_reg) begin
                    t_next     = start_reg;
                    bprio_next = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    state_next = S_W2_RD;
                end else begin
                    state_next = S_W1_RD;
                end
            end
            S_W2_RD: begin
                req.re     = 1'b1;
                req.raddr  = t_reg;
                state_next = S_W2_DAT;
            end
            S_W2_DAT: begin
                // strictly greater, so the first met wins a tie
                if (!r.sleeping && r.prio > bprio_reg) begin
                    bprio_next = r.prio;
                    best_next  = t_reg;
                    found_next = 1'b1;
                end
                t_next = r.succ;
                if (r.succ == start_reg) begin
                    state_next = S_PICK_RD;
                end else begin
                    state_next = S_W2_RD;
                end
            end
            S_PICK_RD: begin
                if (found_reg) begin
                    cur_next = best_reg;
                end
                req.re     = 1'b1;
                req.raddr  = found_reg ? best_reg : cur_reg;
                state_next = S_PICK_DAT;
            end
            S_PICK_DAT: begin
                r.cpu     = r.cpu + 32'd1;
                req.we    = 1'b1;
                req.waddr = cur_reg;
                req.wdata = r;
                res_next.ctx    = r.ctx;
                res_next.slot   = cur_reg;
                res_next.id     = r.id;
                res_next.cpu    = r.cpu;
                res_next.new_id = '0;
                res_next.status = STAT_SCHED;
                state_next      = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res       = res_reg;
        res.tasks = count_reg + slot_t'(1);
    end

endmodule
